@@ hdl/mbps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_pkg: shared constants and types of the masked byte pattern scanner
// Register indexes, mode codes, widths and the item record passed between the
// tally stage and the decision stage.
// ----------------------------------------------------------------------------
package mbps_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int OFFSET_BITS = 32;
    localparam int LEN_BITS    = $clog2(MAX_PATTERN + 1);
    localparam int IDX_BITS    = $clog2(MAX_PATTERN);
    localparam int CFG_BITS    = 3;
    localparam int CFG_WIDTH   = 64;
    localparam int THR_BITS    = 9;
    localparam int PROD_BITS   = THR_BITS + LEN_BITS;

    localparam logic [CFG_BITS-1:0] CFG_PAT_LO    = 3'd0;
    localparam logic [CFG_BITS-1:0] CFG_PAT_HI    = 3'd1;
    localparam logic [CFG_BITS-1:0] CFG_CARE_MASK = 3'd2;
    localparam logic [CFG_BITS-1:0] CFG_LENGTH    = 3'd3;
    localparam logic [CFG_BITS-1:0] CFG_BASE      = 3'd4;
    localparam logic [CFG_BITS-1:0] CFG_MODE      = 3'd5;
    localparam logic [CFG_BITS-1:0] CFG_THRESHOLD = 3'd6;

    localparam logic [1:0] MODE_ALL   = 2'd0;
    localparam logic [1:0] MODE_FIRST = 2'd1;
    localparam logic [1:0] MODE_FUZZY = 2'd2;

    localparam logic [THR_BITS-1:0] THR_FULL = 9'd256;

    typedef logic [OFFSET_BITS-1:0] offset_t;

    typedef struct packed {
        logic                eob;
        logic                complete;
        offset_t             offset;
        logic [LEN_BITS-1:0] matched;
    } tally_t;

    function automatic logic [7:0] pat_at(input logic [127:0] pat,
                                          input logic [IDX_BITS-1:0] idx);
        pat_at = pat[{idx, 3'b000} +: 8];
    endfunction

endpackage

@@ hdl/mbps_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_if: item channels of the masked byte pattern scanner
// Byte channel into the scanner and result channel out of it, valid/ready.
// ----------------------------------------------------------------------------
interface mbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface mbps_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] match_offset;
    logic [63:0] match_address;
    logic [4:0]  matched_count;
    logic [4:0]  care_count;
    logic        last;

    modport source (output valid, output found, output match_offset, output match_address,
                    output matched_count, output care_count, output last, input ready);
    modport sink   (input valid, input found, input match_offset, input match_address,
                    input matched_count, input care_count, input last, output ready);
endinterface

@@ hdl/masked_byte_pattern_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan: wildcard byte signature scanner
// A row of window cells compares the latest bytes with a masked pattern;
// exact, first-exact and fuzzy first-or-best reporting per buffer.
// ----------------------------------------------------------------------------
//  channel    dir  payload                                            handshake
//  byte_ch    in   data_byte, end_of_buffer                           valid/ready
//  result_ch  out  found, match_offset, match_address, matched_count, valid/ready
//                  care_count, last
//  cfg        in   cfg_index, cfg_wdata                               cfg_we
//
//  One item per cycle sustained while result_ch.ready is high; a result is
//  presented after its item has passed the cell row (loaded on the edge that
//  takes the item), then the tally register, then the result register.
//  The cell row, tally and result register each hold one item; a stalled
//  result register backs up the stages behind it before byte_ch.ready drops.
//  Reset clears the window, counters and configuration at once; no sweep.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scan (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mbps_pkg::CFG_BITS-1:0]  cfg_index,
    input  logic [mbps_pkg::CFG_WIDTH-1:0] cfg_wdata,
    mbps_in_if.sink                        byte_ch,
    mbps_out_if.source                     result_ch
);
    import mbps_pkg::*;

    logic [63:0]          pat_lo_reg;
    logic [63:0]          pat_hi_reg;
    logic [15:0]          care_reg;
    logic [4:0]           len_reg;
    logic [63:0]          base_reg;
    logic [1:0]           mode_reg;
    logic [THR_BITS-1:0]  thr_reg;
    logic [LEN_BITS-1:0]  cares_reg;
    logic [LEN_BITS-1:0]  cares_next;

    offset_t              seen_reg;
    offset_t              seen_next;
    offset_t              seen_inc;
    logic                 cell_valid_reg;
    logic                 cell_valid_next;
    logic                 cell_eob_reg;
    logic                 cell_complete_reg;
    offset_t              cell_offset_reg;

    logic [LEN_BITS-1:0]  len_c;
    logic [127:0]         pattern;
    logic                 accept;
    logic                 complete;
    logic                 cell_go;
    logic                 tally_valid;
    logic                 tally_free;
    logic                 dec_go;
    tally_t               tally_item;

    logic [7:0]             win [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] hits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg <= '0;
            pat_hi_reg <= '0;
            care_reg   <= '0;
            len_reg    <= 5'd1;
            base_reg   <= '0;
            mode_reg   <= MODE_ALL;
            thr_reg    <= THR_FULL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PAT_LO:    pat_lo_reg <= cfg_wdata;
                CFG_PAT_HI:    pat_hi_reg <= cfg_wdata;
                CFG_CARE_MASK: care_reg   <= cfg_wdata[15:0];
                CFG_LENGTH:    len_reg    <= cfg_wdata[4:0];
                CFG_BASE:      base_reg   <= cfg_wdata;
                CFG_MODE:      mode_reg   <= cfg_wdata[1:0];
                CFG_THRESHOLD: thr_reg    <= cfg_wdata[THR_BITS-1:0];
                default:       ;
            endcase
        end
    end

    assign len_c   = (LEN_BITS'(len_reg) > LEN_BITS'(MAX_PATTERN))
                     ? LEN_BITS'(MAX_PATTERN) : LEN_BITS'(len_reg);
    assign pattern = {pat_hi_reg, pat_lo_reg};

    always_comb
    begin
        cares_next = '0;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            if (care_reg[k] && (LEN_BITS'(k) < len_c))
            begin
                cares_next = cares_next + LEN_BITS'(1);
            end
        end
    end

    // byte counter and window position of the incoming item
    assign accept   = byte_ch.valid && byte_ch.ready;
    assign seen_inc = (seen_reg == '1) ? seen_reg : seen_reg + OFFSET_BITS'(1);
    assign complete = (len_c != '0) && (seen_inc >= OFFSET_BITS'(len_c));

    always_comb
    begin
        seen_next       = seen_reg;
        cell_valid_next = cell_valid_reg;
        if (accept)
        begin
            seen_next       = byte_ch.end_of_buffer ? '0 : seen_inc;
            cell_valid_next = 1'b1;
        end
        else if (cell_go)
        begin
            cell_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= '0;
            cell_valid_reg <= 1'b0;
            cares_reg      <= '0;
        end
        else
        begin
            seen_reg       <= seen_next;
            cell_valid_reg <= cell_valid_next;
            cares_reg      <= cares_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cell_eob_reg      <= byte_ch.end_of_buffer;
            cell_complete_reg <= complete;
            cell_offset_reg   <= seen_inc - OFFSET_BITS'(len_c);
        end
    end

    // cell row: cell k holds the byte k positions back and checks pattern
    // slot len-1-k
    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++)
        begin : g_cell
            logic [LEN_BITS-1:0] slot;
            logic                in_use;
            logic [7:0]          src;

            assign slot   = len_c - LEN_BITS'(k) - LEN_BITS'(1);
            assign in_use = LEN_BITS'(k) < len_c;

            if (k == 0)
            begin : g_head
                assign src = byte_ch.data_byte;
            end
            else
            begin : g_body
                assign src = win[k-1];
            end

            mbps_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift    (accept),
                .data_in  (src),
                .pat_byte (pat_at(pattern, slot[IDX_BITS-1:0])),
                .care     (in_use && care_reg[slot[IDX_BITS-1:0]]),
                .data_out (win[k]),
                .hit      (hits[k])
            );
        end
    endgenerate

    assign tally_free    = !tally_valid || dec_go;
    assign cell_go       = cell_valid_reg && tally_free;
    assign byte_ch.ready = !cell_valid_reg || cell_go;

    mbps_tally u_tally (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cell_go),
        .drain    (dec_go),
        .hits     (hits),
        .eob      (cell_eob_reg),
        .complete (cell_complete_reg),
        .offset   (cell_offset_reg),
        .valid    (tally_valid),
        .item     (tally_item)
    );

    mbps_decide u_decide (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid        (tally_valid),
        .item         (tally_item),
        .mode         (mode_reg),
        .threshold    (thr_reg),
        .cares        (cares_reg),
        .base_address (base_reg),
        .go           (dec_go),
        .result_ch    (result_ch)
    );
endmodule

@@ hdl/mbps_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_cell: one window position of the scanner
// Holds one window byte, hands it to the next cell on each shift and records
// whether the incoming byte matches the pattern byte assigned to this slot.
// ----------------------------------------------------------------------------
module mbps_cell (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift,
    input  logic [7:0] data_in,
    input  logic [7:0] pat_byte,
    input  logic       care,
    output logic [7:0] data_out,
    output logic       hit
);
    logic [7:0] data_reg;
    logic [7:0] data_next;
    logic       hit_reg;
    logic       hit_next;

    always_comb
    begin
        data_next = data_reg;
        hit_next  = hit_reg;
        if (shift)
        begin
            data_next = data_in;
            hit_next  = care && (data_in == pat_byte);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            data_reg <= data_next;
            hit_reg  <= hit_next;
        end
    end

    assign data_out = data_reg;
    assign hit      = hit_reg;
endmodule

@@ hdl/mbps_tally.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_tally: match count stage
// Counts the hit flags of the cell row and registers the count with the
// item's window position.
// ----------------------------------------------------------------------------
module mbps_tally (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  logic                            drain,
    input  logic [mbps_pkg::MAX_PATTERN-1:0] hits,
    input  logic                            eob,
    input  logic                            complete,
    input  mbps_pkg::offset_t               offset,
    output logic                            valid,
    output mbps_pkg::tally_t                item
);
    import mbps_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    tally_t              item_reg;
    tally_t              item_next;
    logic [LEN_BITS-1:0] count;

    always_comb
    begin
        count = '0;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            count = count + LEN_BITS'(hits[k]);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (load)
        begin
            valid_next         = 1'b1;
            item_next.eob      = eob;
            item_next.complete = complete;
            item_next.offset   = offset;
            item_next.matched  = count;
        end
        else if (drain)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign valid = valid_reg;
    assign item  = item_reg;
endmodule

@@ hdl/mbps_decide.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_decide: match decision and result register
// Applies the scan mode, keeps the per-buffer hit and best-window record and
// loads the result register that drives the result channel.
// ----------------------------------------------------------------------------
module mbps_decide (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               valid,
    input  mbps_pkg::tally_t                   item,
    input  logic [1:0]                         mode,
    input  logic [mbps_pkg::THR_BITS-1:0]      threshold,
    input  logic [mbps_pkg::LEN_BITS-1:0]      cares,
    input  logic [63:0]                        base_address,
    output logic                               go,
    mbps_out_if.source                         result_ch
);
    import mbps_pkg::*;

    logic                hit_rep_reg;
    logic                hit_rep_next;
    logic [LEN_BITS-1:0] best_m_reg;
    logic [LEN_BITS-1:0] best_m_next;
    offset_t             best_off_reg;
    offset_t             best_off_next;
    logic                res_valid_reg;
    logic                res_valid_next;
    logic                found_reg;
    logic                found_next;
    logic [31:0]         offset_reg;
    logic [31:0]         offset_next;
    logic [63:0]         address_reg;
    logic [63:0]         address_next;
    logic [4:0]          matched_reg;
    logic [4:0]          matched_next;
    logic [4:0]          cares_reg;
    logic [4:0]          cares_next;
    logic                last_reg;
    logic                last_next;

    logic                fuzzy;
    logic                thr_ok;
    logic                eligible;
    logic                reach;
    logic                better;
    logic [LEN_BITS-1:0] best_m_upd;
    offset_t             best_off_upd;
    logic                hit;
    logic                want;
    logic                f;
    offset_t             off;
    logic [LEN_BITS-1:0] mc;
    logic                out_free;

    always_comb
    begin
        fuzzy    = (mode == MODE_FUZZY);
        thr_ok   = (threshold <= THR_FULL);
        eligible = item.complete && thr_ok && !hit_rep_reg && (cares != '0);
        reach    = PROD_BITS'({item.matched, 8'h00})
                   >= (PROD_BITS'(threshold) * PROD_BITS'(cares));
        better       = eligible && (item.matched > best_m_reg);
        best_m_upd   = better ? item.matched : best_m_reg;
        best_off_upd = better ? item.offset : best_off_reg;

        hit  = 1'b0;
        want = 1'b0;
        f    = 1'b0;
        off  = '0;
        mc   = '0;
        if (fuzzy)
        begin
            hit = eligible && reach;
            if (hit)
            begin
                want = 1'b1;
                f    = 1'b1;
                off  = item.offset;
                mc   = item.matched;
            end
            else if (item.eob)
            begin
                want = 1'b1;
                if (thr_ok && !hit_rep_reg && (best_m_upd != '0))
                begin
                    f   = 1'b1;
                    off = best_off_upd;
                    mc  = best_m_upd;
                end
            end
        end
        else
        begin
            hit = item.complete && (item.matched == cares)
                  && ((mode != MODE_FIRST) || !hit_rep_reg);
            if (hit)
            begin
                want = 1'b1;
                f    = 1'b1;
                off  = item.offset;
                mc   = item.matched;
            end
            else if (item.eob)
            begin
                want = 1'b1;
            end
        end

        out_free = !res_valid_reg || result_ch.ready;
        go       = valid && (!want || out_free);
    end

    always_comb
    begin
        hit_rep_next   = hit_rep_reg;
        best_m_next    = best_m_reg;
        best_off_next  = best_off_reg;
        res_valid_next = res_valid_reg;
        found_next     = found_reg;
        offset_next    = offset_reg;
        address_next   = address_reg;
        matched_next   = matched_reg;
        cares_next     = cares_reg;
        last_next      = last_reg;

        if (go)
        begin
            if (item.eob)
            begin
                hit_rep_next  = 1'b0;
                best_m_next   = '0;
                best_off_next = '0;
            end
            else
            begin
                hit_rep_next = hit_rep_reg || hit;
                if (fuzzy)
                begin
                    best_m_next   = best_m_upd;
                    best_off_next = best_off_upd;
                end
            end
        end

        if (go && want)
        begin
            res_valid_next = 1'b1;
            found_next     = f;
            offset_next    = 32'(off);
            address_next   = f ? (base_address + 64'(32'(off))) : 64'd0;
            matched_next   = 5'(mc);
            cares_next     = 5'(cares);
            last_next      = item.eob;
        end
        else if (result_ch.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_rep_reg   <= 1'b0;
            best_m_reg    <= '0;
            best_off_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            hit_rep_reg   <= hit_rep_next;
            best_m_reg    <= best_m_next;
            best_off_reg  <= best_off_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg   <= found_next;
        offset_reg  <= offset_next;
        address_reg <= address_next;
        matched_reg <= matched_next;
        cares_reg   <= cares_next;
        last_reg    <= last_next;
    end

    assign result_ch.valid         = res_valid_reg;
    assign result_ch.found         = found_reg;
    assign result_ch.match_offset  = offset_reg;
    assign result_ch.match_address = address_reg;
    assign result_ch.matched_count = matched_reg;
    assign result_ch.care_count    = cares_reg;
    assign result_ch.last          = last_reg;
endmodule
